[src/double_ended_queue_defines.svh]
// Assertion macros shared by the double-ended queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a condition in one cycle implies another in the same cycle.
`define DQ_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("double_ended_queue: same-cycle check failed");
// Check that a condition in one cycle implies another in the next cycle.
`define DQ_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("double_ended_queue: next-cycle check failed");
`else
`define DQ_ASSERT_IMPLY(name, ck, rs, ante, cons)
`define DQ_ASSERT_NEXT(name, ck, rs, ante, cons)
`endif

`endif

[src/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
// No dependencies; imported by the top, the controller, the datapath and the testbench.
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int KIND_W   = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } dq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
  } dq_cmd_t;

endpackage

`default_nettype wire

[src/double_ended_queue.sv]
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_ctrl, dq_datapath and the assertion macro header.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, kind, push_value | into block
//  out     | out_valid, out_stall, pop_value, status, held_after | out of block
//
// An operation passes through the accept state, which updates the ring indexes
// and starts the single store access, and then the result state, which waits
// on the registered RAM read. Results sit in an output register, so an item
// is accepted while an earlier result is still waiting. A stalled output
// holds the block in its result state. Reset empties the queue at once.
`default_nettype none
`include "double_ended_queue_defines.svh"

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic        [KIND_W-1:0]   kind,
  input  wire logic signed [WORD_W-1:0]   push_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed      [WORD_W-1:0]   pop_value,
  output logic             [STATUS_W-1:0] status,
  output logic             [HELD_W-1:0]   held_after
);

  dq_cmd_t cmd;
  logic    res_full, res_empty;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind       (kind),
    .push_value (push_value),
    .pop_value  (pop_value),
    .status     (status),
    .held_after (held_after)
  );

  assign res_full  = out_valid && (status == STATUS_FULL);
  assign res_empty = out_valid && (status == STATUS_EMPTY);

  `DQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.accept, in_stall)
  `DQ_ASSERT_IMPLY(a_full_count, clk, rst, res_full, held_after == HELD_W'(DEPTH))
  `DQ_ASSERT_IMPLY(a_empty_result, clk, rst, res_empty, (held_after == '0) && (pop_value == '0))

endmodule

`default_nettype wire

[src/dq_ram.sv]
// Generic single-port RAM with registered read and read enable.
// No dependencies; used for the deque word store.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[src/dq_ctrl.sv]
// Controller for the double-ended queue: sequences accept and result load.
// Depends on dq_pkg for the state enum and the command struct.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic out_stall,
  output logic      in_stall,
  output logic      out_valid,
  output dq_cmd_t   cmd
);

  dq_state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_RESULT: begin
        cmd.load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/dq_datapath.sv]
// Datapath for the double-ended queue: ring indexes, count, store, result.
// Depends on dq_pkg and dq_ram.
`default_nettype none

module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dq_cmd_t                    cmd,
  input  wire logic        [KIND_W-1:0]   kind,
  input  wire logic signed [WORD_W-1:0]   push_value,
  output logic signed      [WORD_W-1:0]   pop_value,
  output logic             [STATUS_W-1:0] status,
  output logic             [HELD_W-1:0]   held_after
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_S = (AW+1)'(DEPTH);

  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [STATUS_W-1:0] res_status;
  logic [HELD_W-1:0]   res_held;
  logic                res_pop;

  logic          is_push, full, empty, push_ok, pop_ok;
  logic [AW:0]   cnt_s, offset;
  logic [AW-1:0] idx;
  logic [WORD_W-1:0] rdata;
  logic [STATUS_W-1:0] status_next;

  // Wrap front plus an offset of at most DEPTH back into the ring.
  function automatic logic [AW-1:0] ring_wrap(input logic [AW-1:0] base,
                                              input logic [AW:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + off;
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  assign is_push = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = is_push && !full;
  assign pop_ok  = !is_push && !empty;
  assign cnt_s   = (AW+1)'(count);

  always_comb begin
    case (kind)
      KIND_PUSH_FRONT: offset = DEPTH_S - (AW+1)'(1);
      KIND_PUSH_BACK:  offset = cnt_s;
      KIND_POP_FRONT:  offset = '0;
      KIND_POP_BACK:   offset = cnt_s - (AW+1)'(1);
      default:         offset = '0;
    endcase
  end

  assign idx = ring_wrap(front, offset);

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = STATUS_DONE;
    if (is_push) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + CW'(1);
        if (kind == KIND_PUSH_FRONT) begin
          front_next = idx;
        end
      end
    end else begin
      if (empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        count_next = count - CW'(1);
        if (kind == KIND_POP_FRONT) begin
          front_next = ring_wrap(front, (AW+1)'(1));
        end
      end
    end
  end

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && push_ok),
    .re    (cmd.accept && pop_ok),
    .addr  (idx),
    .wdata (push_value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status <= status_next;
      res_held   <= HELD_W'(count_next);
      res_pop    <= pop_ok;
    end
    if (cmd.load) begin
      pop_value  <= res_pop ? $signed(rdata) : '0;
      status     <= res_status;
      held_after <= res_held;
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for double_ended_queue: random and directed deque operations.
// It predicts every result with its own ring model. Depends on dq_pkg and the RTL top.
`default_nettype none

module tb;
  import dq_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEFAULT;
  localparam int STUCK_LIMIT = 2000;
  localparam int SEG_LEN     = 96;
  localparam int SEG_COUNT   = 18;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
  } deque_op_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;
    logic [HELD_W-1:0]        held_after;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [KIND_W-1:0]          kind = KIND_PUSH_BACK;
  logic signed [WORD_W-1:0]   push_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [WORD_W-1:0]   pop_value;
  logic [STATUS_W-1:0]        status;
  logic [HELD_W-1:0]          held_after;

  deque_op_t     pending_ops[$];
  deque_result_t expected_results[$];

  logic [WORD_W-1:0] ring_words[RING_DEPTH];
  int                ring_front = 0;
  int                ring_count = 0;

  int   accepted = 0;
  int   errors = 0;
  logic in_fire = 1'b0;
  logic calm;

  // No idling on either side for a stretch in the middle of the run.
  assign calm = (accepted >= 700) && (accepted < 1000);

  double_ended_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pop_value (pop_value),
    .status    (status),
    .held_after(held_after)
  );

  always #5 clk = ~clk;

  // Apply one operation to the ring copy and return the result it yields.
  function automatic deque_result_t apply_deque_op(deque_op_t op);
    deque_result_t r;
    int            slot;
    r.pop_value = '0;
    r.status    = STATUS_DONE;
    if (op.kind == KIND_PUSH_FRONT || op.kind == KIND_PUSH_BACK) begin
      if (ring_count >= RING_DEPTH) begin
        r.status = STATUS_FULL;
      end else if (op.kind == KIND_PUSH_FRONT) begin
        ring_front = (ring_front + RING_DEPTH - 1) % RING_DEPTH;
        ring_words[ring_front] = op.value;
        ring_count++;
      end else begin
        slot = (ring_front + ring_count) % RING_DEPTH;
        ring_words[slot] = op.value;
        ring_count++;
      end
    end else begin
      if (ring_count == 0) begin
        r.status = STATUS_EMPTY;
      end else if (op.kind == KIND_POP_FRONT) begin
        r.pop_value = ring_words[ring_front];
        ring_front = (ring_front + 1) % RING_DEPTH;
        ring_count--;
      end else begin
        slot = (ring_front + ring_count - 1) % RING_DEPTH;
        r.pop_value = ring_words[slot];
        ring_count--;
      end
    end
    r.held_after = ring_count[HELD_W-1:0];
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [KIND_W-1:0] k, logic [WORD_W-1:0] v);
    deque_op_t op;
    op.kind  = k;
    op.value = v;
    pending_ops.push_back(op);
  endtask

  // Driver: advance to the next item once the current one transfers.
  always @(negedge clk) begin
    deque_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        op = pending_ops.pop_front();
        in_valid   <= 1'b1;
        kind       <= op.kind;
        push_value <= op.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 16);
  end

  // Monitor: check the result transfer first, then record the input transfer.
  always @(posedge clk) begin
    deque_result_t want;
    deque_op_t     op;
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: pop_value %0d status %0d held_after %0d",
                 pop_value, status, held_after);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (pop_value !== want.pop_value) begin
            $error("pop_value: expected %0d, got %0d", want.pop_value, pop_value);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (held_after !== want.held_after) begin
            $error("held_after: expected %0d, got %0d", want.held_after, held_after);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        op.kind  = kind;
        op.value = push_value;
        expected_results.push_back(apply_deque_op(op));
        accepted++;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
        stuck = 0;
      else
        stuck++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int push_pct;
    logic [KIND_W-1:0] k;

    // Directed: empty pops, word extremes, both ends, drain back to empty.
    queue_op(KIND_POP_FRONT, 32'h1234_5678);
    queue_op(KIND_POP_BACK, '1);
    queue_op(KIND_PUSH_BACK, 32'h7fff_ffff);
    queue_op(KIND_PUSH_FRONT, 32'h8000_0000);
    queue_op(KIND_PUSH_BACK, '0);
    queue_op(KIND_PUSH_FRONT, '1);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_POP_FRONT, '0);
    queue_op(KIND_POP_FRONT, '1);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_PUSH_FRONT, 32'h5555_aaaa);
    queue_op(KIND_POP_BACK, '0);
    queue_op(KIND_POP_FRONT, '0);

    // Random segments alternate between filling and draining bias so the ring
    // wraps and hits both the full and the empty limit.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg % 6)
        0: push_pct = 92;
        1: push_pct = 50;
        2: push_pct = 8;
        3: push_pct = 75;
        4: push_pct = 25;
        default: push_pct = 97;
      endcase
      for (int i = 0; i < SEG_LEN; i++) begin
        if ($urandom_range(99) < push_pct)
          k = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else
          k = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        queue_op(k, pick_word());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
